[hdl/huffman_tree_bit_decoder_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the Huffman tree decoder.
// Concurrent checks are compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define HDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdt assertion failed");
// Next-cycle implication.
`define HDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdt assertion failed");
`else
`define HDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/hdt_pkg.sv]
// ---------------------------------------------------------------------------
// hdt_pkg
// Types and constants shared by the Huffman tree decoder modules.
// ---------------------------------------------------------------------------
package hdt_pkg;

  localparam int NODE_W     = 9;
  localparam int SYM_W      = 8;
  localparam int LIMIT_W    = 32;
  localparam int BYTE_W     = 8;
  localparam int NBITS_W    = 4;
  localparam int BYTE_TOP_BIT = 7;
  localparam logic [NBITS_W-1:0] MAX_BITS = 4'd8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_INDEX   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_LIMIT = 1'b1;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_NODE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CODE  = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_CODE  = 2'd2
  } op_t;

  // One node of the code tree as held in the table.
  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic              leaf;
    logic [SYM_W-1:0]  sym;
  } entry_t;

  // A classified command waiting for the walk engine.
  typedef struct packed {
    op_t                op;
    logic [NODE_W-1:0]  index;
    entry_t             entry;
    logic [BYTE_W-1:0]  code;
    logic [NBITS_W-1:0] nbits;
  } cmd_t;

  typedef struct packed {
    logic   valid;
    cmd_t   cmd;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [NODE_W-1:0]  root;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

endpackage

[hdl/hdt_if.sv]
// ---------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for input words and decoded result words.
// ---------------------------------------------------------------------------
interface hdt_in_if;
  logic                          valid;
  logic                          ready;
  logic [hdt_pkg::KIND_W-1:0]    kind;
  logic [hdt_pkg::NODE_W-1:0]    node_index;
  logic [hdt_pkg::NODE_W-1:0]    left_child;
  logic [hdt_pkg::NODE_W-1:0]    right_child;
  logic                          is_leaf;
  logic [hdt_pkg::SYM_W-1:0]     leaf_symbol;
  logic [hdt_pkg::BYTE_W-1:0]    code_byte;
  logic [hdt_pkg::NBITS_W-1:0]   valid_bits;

  modport source (output valid, kind, node_index, left_child, right_child, is_leaf,
                  leaf_symbol, code_byte, valid_bits, input ready);
  modport sink   (input valid, kind, node_index, left_child, right_child, is_leaf,
                  leaf_symbol, code_byte, valid_bits, output ready);
endinterface

interface hdt_out_if;
  logic                      valid;
  logic                      ready;
  logic [hdt_pkg::SYM_W-1:0] symbol;
  logic                      last_of_run;
  logic                      done_res;

  modport source (output valid, symbol, last_of_run, done_res, input ready);
  modport sink   (input valid, symbol, last_of_run, done_res, output ready);
endinterface

[hdl/hdt_front.sv]
// ---------------------------------------------------------------------------
// hdt_front
// Accepts input words, classifies them and pushes commands into the queue.
// ---------------------------------------------------------------------------
module hdt_front #(
  parameter int NODE_DEPTH = 512
) (
  hdt_in_if.sink           in_chan,
  input  hdt_pkg::q_status_t q_status,
  output hdt_pkg::push_t   push
);

  localparam logic [hdt_pkg::NODE_W:0] DEPTH_L = (hdt_pkg::NODE_W+1)'(NODE_DEPTH);

  logic accept;
  logic keep;
  logic in_range;

  // A word is taken whenever the queue has room.
  assign in_chan.ready = !q_status.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign in_range      = {1'b0, in_chan.node_index} < DEPTH_L;

  // Classify the word; writes beyond the table, empty code words and words of unknown kind are dropped.
  always_comb begin
    push.cmd.index       = in_chan.node_index;
    push.cmd.entry.left  = in_chan.left_child;
    push.cmd.entry.right = in_chan.right_child;
    push.cmd.entry.leaf  = in_chan.is_leaf;
    push.cmd.entry.sym   = in_chan.leaf_symbol;
    push.cmd.code        = in_chan.code_byte;
    push.cmd.nbits       = (in_chan.valid_bits > hdt_pkg::MAX_BITS) ? hdt_pkg::MAX_BITS
                                                                    : in_chan.valid_bits;
    case (in_chan.kind)
      hdt_pkg::KIND_NODE: begin
        push.cmd.op = hdt_pkg::OP_WRITE;
        keep        = in_range;
      end
      hdt_pkg::KIND_START: begin
        push.cmd.op = hdt_pkg::OP_START;
        keep        = 1'b1;
      end
      hdt_pkg::KIND_CODE: begin
        push.cmd.op = hdt_pkg::OP_CODE;
        keep        = (in_chan.valid_bits != '0);
      end
      default: begin
        push.cmd.op = hdt_pkg::OP_CODE;
        keep        = 1'b0;
      end
    endcase
    push.valid = accept && keep;
  end

endmodule

[hdl/hdt_queue.sv]
// ---------------------------------------------------------------------------
// hdt_queue
// Short command queue between the front end and the walk engine.
// ---------------------------------------------------------------------------
module hdt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  hdt_pkg::push_t     push,
  input  logic               pop,
  output hdt_pkg::cmd_t      head,
  output hdt_pkg::q_status_t status
);

  hdt_pkg::cmd_t               slot_r [hdt_pkg::QUEUE_DEPTH];
  logic [hdt_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [hdt_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [hdt_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign status.full  = (count_r == hdt_pkg::QCNT_W'(hdt_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = slot_r[rd_ptr_r];
  assign do_push      = push.valid && !status.full;
  assign do_pop       = pop && !status.empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + hdt_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - hdt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

[hdl/hdt_back.sv]
// ---------------------------------------------------------------------------
// hdt_back
// Walk engine: holds the node table, steps through code bits and drives
// the result register.
// ---------------------------------------------------------------------------
module hdt_back #(
  parameter int NODE_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hdt_pkg::cfg_t      cfg,
  input  hdt_pkg::cmd_t      head,
  input  hdt_pkg::q_status_t q_status,
  output logic               pop,
  hdt_out_if.source          out_chan
);

  localparam int AW = $clog2(NODE_DEPTH);
  localparam logic [hdt_pkg::NODE_W:0] DEPTH_L = (hdt_pkg::NODE_W+1)'(NODE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIRST = 4'b0010,
    S_WALK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  hdt_pkg::entry_t mem [NODE_DEPTH];

  state_t                          state_r, state_nxt;
  logic [hdt_pkg::NODE_W-1:0]      cur_idx_r, cur_idx_nxt;
  logic [hdt_pkg::LIMIT_W-1:0]     cnt_r, cnt_nxt;
  logic [hdt_pkg::BYTE_W-1:0]      sh_r, sh_nxt;
  logic [hdt_pkg::NBITS_W-1:0]     left_r, left_nxt;
  logic                            pend_valid_r, pend_valid_nxt;
  logic [hdt_pkg::SYM_W-1:0]       pend_sym_r, pend_sym_nxt;
  logic                            pend_done_r, pend_done_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [hdt_pkg::SYM_W-1:0]       out_sym_r;
  logic                            out_last_r;
  logic                            out_done_r;

  hdt_pkg::entry_t                 rda_r, rdb_r;
  logic                            rda_ok_r, rdb_ok_r;
  logic [hdt_pkg::NODE_W-1:0]      adr_a_r;

  hdt_pkg::entry_t                 ent_a, ent_b, cur_eff;
  logic [hdt_pkg::NODE_W-1:0]      rd_addr_a;
  logic                            rd_en;
  logic                            wr_en;
  logic                            slot_free;
  logic                            emit;
  logic                            emit_last;
  logic [hdt_pkg::LIMIT_W-1:0]     cnt_inc;
  logic                            done_new;
  logic                            stall;
  logic                            finish;

  // Entries outside the table read as zero.
  assign ent_a = rda_ok_r ? rda_r : '0;
  assign ent_b = rdb_ok_r ? rdb_r : '0;

  // After a leaf the walk carries on from the root entry fetched alongside.
  assign cur_eff   = ((state_r == S_WALK) && ent_a.leaf) ? ent_b : ent_a;
  assign rd_addr_a = (state_r == S_IDLE) ? cur_idx_r
                                         : (sh_r[hdt_pkg::BYTE_TOP_BIT] ? cur_eff.right
                                                                        : cur_eff.left);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign cnt_inc   = cnt_r + hdt_pkg::LIMIT_W'(1);
  assign done_new  = (cnt_inc >= cfg.limit);
  assign stall     = ent_a.leaf && pend_valid_r && !slot_free;
  assign finish    = (left_r == hdt_pkg::NBITS_W'(1)) || (ent_a.leaf && done_new);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cur_idx_nxt    = cur_idx_r;
    cnt_nxt        = cnt_r;
    sh_nxt         = sh_r;
    left_nxt       = left_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_done_nxt  = pend_done_r;
    pop            = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    emit           = 1'b0;
    emit_last      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          case (head.op)
            hdt_pkg::OP_WRITE: begin
              wr_en = 1'b1;
            end
            hdt_pkg::OP_START: begin
              cur_idx_nxt = cfg.root;
              cnt_nxt     = '0;
            end
            hdt_pkg::OP_CODE: begin
              rd_en     = 1'b1;
              sh_nxt    = head.code;
              left_nxt  = head.nbits;
              state_nxt = S_FIRST;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_FIRST: begin
        // The current entry is in hand; fetch the child of the first bit.
        rd_en = 1'b1;
        if ((cnt_r >= cfg.limit) || (left_r == '0)) begin
          state_nxt = S_IDLE;
        end else begin
          sh_nxt    = {sh_r[hdt_pkg::BYTE_W-2:0], 1'b0};
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!stall) begin
          rd_en    = 1'b1;
          sh_nxt   = {sh_r[hdt_pkg::BYTE_W-2:0], 1'b0};
          left_nxt = left_r - hdt_pkg::NBITS_W'(1);
          if (ent_a.leaf) begin
            // A newer symbol exists, so the held one is not the last.
            emit           = pend_valid_r;
            cnt_nxt        = cnt_inc;
            pend_valid_nxt = 1'b1;
            pend_sym_nxt   = ent_a.sym;
            pend_done_nxt  = done_new;
            cur_idx_nxt    = cfg.root;
          end else begin
            cur_idx_nxt = adr_a_r;
          end
          if (finish) begin
            state_nxt = (ent_a.leaf || pend_valid_r) ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          emit           = 1'b1;
          emit_last      = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_idx_r    <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_idx_r    <= cur_idx_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sh_r        <= sh_nxt;
    left_r      <= left_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_done_r <= pend_done_nxt;
    if (emit) begin
      out_sym_r  <= pend_sym_r;
      out_last_r <= emit_last;
      out_done_r <= pend_done_r;
    end
  end

  // Node table: one write port, two registered read ports (walk and root).
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head.index[AW-1:0]] <= head.entry;
    end
    if (rd_en) begin
      rda_r    <= mem[rd_addr_a[AW-1:0]];
      rdb_r    <= mem[cfg.root[AW-1:0]];
      rda_ok_r <= ({1'b0, rd_addr_a} < DEPTH_L);
      rdb_ok_r <= ({1'b0, cfg.root} < DEPTH_L);
      adr_a_r  <= rd_addr_a;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.symbol      = out_sym_r;
  assign out_chan.last_of_run = out_last_r;
  assign out_chan.done_res    = out_done_r;

endmodule

[hdl/huffman_tree_bit_decoder.sv]
// ---------------------------------------------------------------------------
// huffman_tree_bit_decoder
// Huffman decoder that walks a code tree held in an on-chip node table.
// ---------------------------------------------------------------------------
//  Channel   Direction  Words
//  in_chan   in         node writes, message starts, code bytes
//  out_chan  out        decoded symbols with last and done flags
//  cfg_*     in         root index and symbol limit writes
//
//  A code byte passes the first-read state, then walks its bits until they run
//  out or the limit stops it, and flushes when a symbol is held at its end; the
//  node table read per bit sets the pace. Node and start words finish in idle.
//  Reset is synchronous; the table itself is not cleared.
//  A two-word queue lets the input side run ahead while results are stalled.
// ---------------------------------------------------------------------------
`include "huffman_tree_bit_decoder_defines.svh"

module huffman_tree_bit_decoder #(
  parameter int NODE_DEPTH = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hdt_in_if.sink                           in_chan,
  hdt_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [hdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hdt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [hdt_pkg::NODE_W-1:0]  root_r;
  logic [hdt_pkg::LIMIT_W-1:0] limit_r;
  hdt_pkg::cfg_t               cfg;
  hdt_pkg::push_t              push;
  hdt_pkg::cmd_t               head;
  hdt_pkg::q_status_t          q_status;
  logic                        pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r  <= '0;
      limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hdt_pkg::CFG_ROOT_INDEX:   root_r  <= cfg_wdata[hdt_pkg::NODE_W-1:0];
        hdt_pkg::CFG_SYMBOL_LIMIT: limit_r <= cfg_wdata[hdt_pkg::LIMIT_W-1:0];
        default: begin
          root_r <= root_r;
        end
      endcase
    end
  end

  assign cfg.root  = root_r;
  assign cfg.limit = limit_r;

  hdt_front #(.NODE_DEPTH(NODE_DEPTH)) u_front (
    .in_chan  (in_chan),
    .q_status (q_status),
    .push     (push)
  );

  hdt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  hdt_back #(.NODE_DEPTH(NODE_DEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // The front end never pushes into a full queue.
  `HDT_ASSERT_IMP(a_no_push_full, clk, rst_n, push.valid, !q_status.full)
  // The engine only pops a queue that holds a word.
  `HDT_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !q_status.empty)
  // A queued word is not lost without a pop.
  `HDT_ASSERT_NEXT(a_queue_holds, clk, rst_n, !q_status.empty && !pop, !q_status.empty)
  // The symbol that reaches the limit always closes its run.
  `HDT_ASSERT_IMP(a_done_is_last, clk, rst_n, out_chan.valid && out_chan.done_res,
                  out_chan.last_of_run)

endmodule
